### rtl/mlt_pkg.sv
// Shared types and constants of the address learning table.
`default_nettype none
package mlt_pkg;
    localparam int TableEntries = 256;
    localparam int IdxW = $clog2(TableEntries);
    localparam int MacW = 48;
    localparam int VlanW = 12;
    localparam int PortW = 6;
    localparam int StampW = 32;
    localparam int CfgW = 16;
    localparam int CfgIdxW = 1;
    localparam int EntryW = MacW + VlanW + PortW + StampW;

    localparam logic [2:0] OpLookup = 3'd0;
    localparam logic [2:0] OpLearn = 3'd1;
    localparam logic [2:0] OpFlush = 3'd2;
    localparam logic [2:0] OpMove = 3'd3;
    localparam logic [2:0] OpTick = 3'd4;

    localparam logic [CfgIdxW-1:0] RegAgingTime = 1'b0;
    localparam logic [CfgIdxW-1:0] RegPurgeInterval = 1'b1;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [MacW-1:0]  mac_address;
        logic [VlanW-1:0] vlan_id;
        logic [PortW-1:0] port_number;
        logic [PortW-1:0] target_port;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [PortW-1:0] found_port;
        logic             refreshed;
        logic             dropped;
    } t_rsp;

    typedef struct packed {
        logic [MacW-1:0]   mac;
        logic [VlanW-1:0]  vlan;
        logic [PortW-1:0]  port;
        logic [StampW-1:0] stamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_PURGE,
        S_FREE,
        S_SWEEP,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

### rtl/mlt_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface mlt_req_if;
    logic          valid;
    logic          ready;
    mlt_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlt_rsp_if;
    logic          valid;
    logic          ready;
    mlt_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/mlt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mlt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/mac_learning_table_with_aging.sv
// Top level: VLAN/MAC to port learning table with time-stamp aging.
//
// channel   dir  handshake     payload
// i_req     in   valid/ready   opcode, mac_address, vlan_id, port_number, target_port
// o_rsp     out  valid/ready   hit, found_port, refreshed, dropped
// cfg       in   i_cfg_we      i_cfg_index, i_cfg_data
//
// One transfer at a time. Lookup and learn scan the entry RAM one slot per
// cycle, then post the result; a learn of a new entry adds a purge pass
// over all 256 slots when the interval has elapsed, then claims the lowest
// free slot. A learn of the all-ones MAC skips the scan. Flush and move
// always sweep all 256 slots. Tick and unused opcodes post their result
// without a scan. The RAM read port sets the rate.
// Valid bits sit in flip-flops and clear on reset; the RAM needs no clearing.
// The result waits in an output register; a stalled sink holds the block.
`default_nettype none
module mac_learning_table_with_aging (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mlt_req_if.sink                            i_req,
    mlt_rsp_if.source                          o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [mlt_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [mlt_pkg::CfgW-1:0]      i_cfg_data
);
    import mlt_pkg::*;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic [TableEntries-1:0] r_valid, n_valid;
    logic [StampW-1:0] r_now, n_now, r_last_purge, n_last_purge;
    logic [CfgW-1:0] r_aging, r_purge_iv;
    logic [IdxW-1:0] r_ridx, n_ridx;   // address presented to RAM
    logic [IdxW-1:0] r_cidx, n_cidx;   // index whose data is on o_rdata
    logic r_cvalid, n_cvalid;          // o_rdata holds a scanned entry
    logic r_rsp_valid, n_rsp_valid;

    logic            we;
    logic [IdxW-1:0] waddr;
    t_entry          wdata, rdata;
    logic [EntryW-1:0] rdata_raw;

    mlt_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_ridx),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    logic cur_valid, match, aged;
    assign cur_valid = r_valid[r_cidx];
    assign match = cur_valid && rdata.mac == r_req.mac_address
                   && rdata.vlan == r_req.vlan_id;
    assign aged = (r_now - rdata.stamp) >= StampW'(r_aging);

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data = r_rsp;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    case (i_req.data.opcode)
                        OpLookup, OpLearn, OpFlush, OpMove: n_state = S_FIND;
                        default: n_state = S_DONE;
                    endcase
                    if (i_req.data.opcode == OpLearn && &i_req.data.mac_address) begin
                        n_state = S_DONE;
                    end
                    if (i_req.data.opcode == OpFlush || i_req.data.opcode == OpMove) begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_FIND: begin
                if (r_cvalid) begin
                    if (match) begin
                        n_state = S_DONE;
                    end else if (r_cidx == LastIdx) begin
                        if (r_req.opcode == OpLearn) begin
                            n_state = ((r_now - r_last_purge) >= StampW'(r_purge_iv))
                                      ? S_PURGE : S_FREE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_PURGE: begin
                if (r_cvalid && r_cidx == LastIdx) begin
                    n_state = S_FREE;
                end
            end
            S_SWEEP: begin
                if (r_cvalid && r_cidx == LastIdx) begin
                    n_state = S_DONE;
                end
            end
            S_FREE:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    logic [IdxW-1:0] free_idx;
    logic            free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IdxW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_now = r_now;
        n_last_purge = r_last_purge;
        n_rsp = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_ridx = r_ridx;
        n_cidx = r_cidx;
        n_cvalid = 1'b0;
        we = 1'b0;
        waddr = r_cidx;
        wdata = rdata;
        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_ridx = '0;
                if (i_req.valid && i_req.ready) begin
                    n_rsp = '0;
                    n_cvalid = 1'b1;
                    n_cidx = '0;
                    n_ridx = IdxW'(1);
                end
            end
            S_FIND, S_PURGE, S_SWEEP: begin
                // each cycle: examine r_cidx, read r_ridx
                if (r_cidx != LastIdx) begin
                    n_cvalid = 1'b1;
                    n_cidx = r_ridx;
                    n_ridx = r_ridx + IdxW'(1);
                end
                if (r_state == S_FIND && match) begin
                    n_cvalid = 1'b0;
                    if (r_req.opcode == OpLookup) begin
                        if (aged) begin
                            n_valid[r_cidx] = 1'b0;
                        end else begin
                            n_rsp.hit = 1'b1;
                            n_rsp.found_port = rdata.port;
                        end
                    end else begin
                        we = 1'b1;
                        wdata.port = r_req.port_number;
                        wdata.stamp = r_now;
                        n_rsp.refreshed = 1'b1;
                    end
                end
                if (r_state == S_FIND && !match && r_cidx == LastIdx
                    && r_req.opcode == OpLearn) begin
                    n_cidx = '0;
                    n_ridx = IdxW'(1);
                    n_cvalid = 1'b1;
                    n_ridx = IdxW'(1);
                end
                if (r_state == S_PURGE && cur_valid && aged) begin
                    n_valid[r_cidx] = 1'b0;
                end
                if (r_state == S_SWEEP && cur_valid && rdata.port == r_req.port_number) begin
                    if (r_req.opcode == OpFlush) begin
                        n_valid[r_cidx] = 1'b0;
                    end else begin
                        we = 1'b1;
                        wdata.port = r_req.target_port;
                    end
                end
            end
            S_FREE: begin
                n_last_purge = r_now;
                if (free_any) begin
                    n_valid[free_idx] = 1'b1;
                    we = 1'b1;
                    waddr = free_idx;
                    wdata.mac = r_req.mac_address;
                    wdata.vlan = r_req.vlan_id;
                    wdata.port = r_req.port_number;
                    wdata.stamp = r_now;
                end else begin
                    n_rsp.dropped = 1'b1;
                end
            end
            S_DONE: begin
                if (r_req.opcode == OpTick) begin
                    n_now = r_now + StampW'(1);
                end
                n_rsp_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_now <= '0;
            r_last_purge <= '0;
            r_aging <= CfgW'(300);
            r_purge_iv <= CfgW'(1);
            r_rsp_valid <= 1'b0;
            r_cvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_now <= n_now;
            r_last_purge <= n_last_purge;
            r_rsp_valid <= n_rsp_valid;
            r_cvalid <= n_cvalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegAgingTime:     r_aging <= i_cfg_data;
                    RegPurgeInterval: r_purge_iv <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        r_ridx <= n_ridx;
        r_cidx <= n_cidx;
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
    end
endmodule
`default_nettype wire

### test/mac_learning_table_with_aging_tb.sv
// Self-checking testbench of the VLAN/MAC learning table with aging.
`default_nettype none
module mac_learning_table_with_aging_tb;
    import mlt_pkg::*;

    localparam int Slots = 256;
    localparam int IdleLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgW-1:0] i_cfg_data = '0;

    mlt_req_if req_ch ();
    mlt_rsp_if rsp_ch ();

    mac_learning_table_with_aging u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the forwarding table, kept in step with accepted requests.
    logic               tbl_valid [Slots];
    logic [MacW-1:0]    tbl_mac [Slots];
    logic [VlanW-1:0]   tbl_vlan [Slots];
    logic [PortW-1:0]   tbl_port [Slots];
    logic [StampW-1:0]  tbl_stamp [Slots];
    logic [StampW-1:0]  clock_now;
    logic [StampW-1:0]  purged_at;
    logic [CfgW-1:0]    age_limit;
    logic [CfgW-1:0]    purge_gap;

    t_rsp expected_rsp [$];
    int mismatches = 0;
    int rsp_seen = 0;
    int req_sent = 0;
    int idle_cycles = 0;
    bit stall_rx = 1'b0;
    int rx_pattern = 0;
    int burst_left = 0;
    bit req_done = 1'b0;

    // A few known stations so lookups and refreshes hit often.
    logic [MacW-1:0]  pool_mac [16];
    logic [VlanW-1:0] pool_vlan [16];

    function automatic bit entry_stale(int i);
        logic [StampW-1:0] d;
        d = clock_now - tbl_stamp[i];
        return d >= StampW'(age_limit);
    endfunction

    function automatic int find_slot(logic [MacW-1:0] m, logic [VlanW-1:0] v);
        for (int i = 0; i < Slots; i++)
            if (tbl_valid[i] && tbl_mac[i] == m && tbl_vlan[i] == v) return i;
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the answer.
    function automatic t_rsp table_apply(t_req r);
        t_rsp o;
        int k;
        int f;
        logic [StampW-1:0] d;
        o = '0;
        case (r.opcode)
            OpLookup: begin
                k = find_slot(r.mac_address, r.vlan_id);
                if (k >= 0) begin
                    if (entry_stale(k)) tbl_valid[k] = 1'b0;
                    else begin
                        o.hit = 1'b1;
                        o.found_port = tbl_port[k];
                    end
                end
            end
            OpLearn: begin
                if (r.mac_address != {MacW{1'b1}}) begin
                    k = find_slot(r.mac_address, r.vlan_id);
                    if (k >= 0) begin
                        tbl_port[k] = r.port_number;
                        tbl_stamp[k] = clock_now;
                        o.refreshed = 1'b1;
                    end else begin
                        d = clock_now - purged_at;
                        if (d >= StampW'(purge_gap))
                            for (int i = 0; i < Slots; i++)
                                if (tbl_valid[i] && entry_stale(i)) tbl_valid[i] = 1'b0;
                        purged_at = clock_now;
                        f = -1;
                        for (int i = Slots - 1; i >= 0; i--)
                            if (!tbl_valid[i]) f = i;
                        if (f >= 0) begin
                            tbl_valid[f] = 1'b1;
                            tbl_mac[f] = r.mac_address;
                            tbl_vlan[f] = r.vlan_id;
                            tbl_port[f] = r.port_number;
                            tbl_stamp[f] = clock_now;
                        end else o.dropped = 1'b1;
                    end
                end
            end
            OpFlush:
                for (int i = 0; i < Slots; i++)
                    if (tbl_valid[i] && tbl_port[i] == r.port_number) tbl_valid[i] = 1'b0;
            OpMove:
                for (int i = 0; i < Slots; i++)
                    if (tbl_valid[i] && tbl_port[i] == r.port_number)
                        tbl_port[i] = r.target_port;
            OpTick: clock_now = clock_now + 1'b1;
            default: ;
        endcase
        return o;
    endfunction

    // Sender: bursts of random length with random gaps, then one transfer.
    // Valid stays up between back-to-back calls and drops only for a gap.
    task automatic send_req(t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        expected_rsp.push_back(table_apply(r));
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_sent++;
    endtask

    // Pause until every answer arrived and the block has settled, then write.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegAgingTime) age_limit = val;
        else purge_gap = val;
    endtask

    function automatic t_req make_req(logic [2:0] op, logic [MacW-1:0] m,
                                      logic [VlanW-1:0] v, logic [PortW-1:0] p,
                                      logic [PortW-1:0] t);
        t_req r;
        r.opcode = op;
        r.mac_address = m;
        r.vlan_id = v;
        r.port_number = p;
        r.target_port = t;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int sel;
        int w;
        sel = $urandom_range(0, 15);
        r.opcode = 3'($urandom_range(0, 7));
        w = $urandom_range(0, 99);
        if (w < 35) r.opcode = OpLearn;
        else if (w < 65) r.opcode = OpLookup;
        else if (w < 85) r.opcode = OpTick;
        else if (w < 90) r.opcode = OpMove;
        else if (w < 94) r.opcode = OpFlush;
        if ($urandom_range(0, 3) != 0) begin
            r.mac_address = pool_mac[sel];
            r.vlan_id = pool_vlan[sel];
        end else begin
            r.mac_address = {$urandom, $urandom};
            r.vlan_id = 12'($urandom);
        end
        r.port_number = 6'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3));
        r.target_port = 6'($urandom);
        return r;
    endfunction

    // Receiver stalls with a slowly changing pattern.
    always @(posedge i_clk) begin
        rx_pattern <= rx_pattern + 1;
        if (rx_pattern % 64 == 0) stall_rx <= ($urandom_range(0, 2) == 0);
        rsp_ch.ready <= stall_rx ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
            end else begin
                t_rsp e;
                e = expected_rsp.pop_front();
                if (rsp_ch.data.hit !== e.hit || rsp_ch.data.found_port !== e.found_port ||
                    rsp_ch.data.refreshed !== e.refreshed ||
                    rsp_ch.data.dropped !== e.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", e, rsp_ch.data);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (!req_ch.valid && expected_rsp.size() == 0 && !req_done))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("FAIL mac_learning_table_with_aging");
            $finish;
        end
    end

    task automatic test_directed();
        send_req(make_req(OpLookup, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(OpLearn, 48'h0, 12'h0, 6'h0, 6'h3f));
        send_req(make_req(OpLearn, {MacW{1'b1}}, 12'hfff, 6'h3f, 6'h0));
        send_req(make_req(OpLookup, {MacW{1'b1}}, 12'hfff, 6'h0, 6'h0));
        send_req(make_req(OpLearn, 48'hffff_ffff_fffe, 12'hfff, 6'h3f, 6'h0));
        send_req(make_req(OpLookup, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(OpLookup, 48'hffff_ffff_fffe, 12'hfff, 6'h0, 6'h0));
        send_req(make_req(OpLearn, 48'h0, 12'h0, 6'h2a, 6'h0));
        send_req(make_req(OpMove, 48'h0, 12'h0, 6'h2a, 6'h15));
        send_req(make_req(OpLookup, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(OpFlush, 48'h0, 12'h0, 6'h15, 6'h0));
        send_req(make_req(OpLookup, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(3'd5, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(3'd7, {MacW{1'b1}}, 12'hfff, 6'h3f, 6'h3f));
        send_req(make_req(OpTick, 48'h0, 12'h0, 6'h0, 6'h0));
    endtask

    // Short aging: entries learned, time advanced past the limit, lookup misses.
    task automatic test_aging();
        write_reg(RegAgingTime, 16'd1);
        write_reg(RegPurgeInterval, 16'd1);
        send_req(make_req(OpLearn, 48'h1234, 12'h5, 6'h7, 6'h0));
        send_req(make_req(OpLookup, 48'h1234, 12'h5, 6'h0, 6'h0));
        send_req(make_req(OpTick, 48'h0, 12'h0, 6'h0, 6'h0));
        send_req(make_req(OpLookup, 48'h1234, 12'h5, 6'h0, 6'h0));
        write_reg(RegAgingTime, 16'd0);
        write_reg(RegPurgeInterval, 16'd0);
        send_req(make_req(OpLearn, 48'h99, 12'h1, 6'h1, 6'h0));
        send_req(make_req(OpLookup, 48'h99, 12'h1, 6'h0, 6'h0));
    endtask

    // Fill the table until learns drop, then flush the ports used.
    task automatic test_full_table();
        write_reg(RegAgingTime, 16'hffff);
        write_reg(RegPurgeInterval, 16'hffff);
        for (int i = 0; i < Slots + 4; i++)
            send_req(make_req(OpLearn, 48'(i + 32'h1000), 12'(i), 6'(i % 4), 6'h0));
        for (int p = 0; p < 4; p++)
            send_req(make_req(OpFlush, 48'h0, 12'h0, 6'(p), 6'h0));
    endtask

    task automatic test_random(int n, logic [CfgW-1:0] age, logic [CfgW-1:0] gap);
        write_reg(RegAgingTime, age);
        write_reg(RegPurgeInterval, gap);
        repeat (n) send_req(random_req());
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < Slots; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i] = '0;
            tbl_vlan[i] = '0;
            tbl_port[i] = '0;
            tbl_stamp[i] = '0;
        end
        for (int i = 0; i < 16; i++) begin
            pool_mac[i] = {$urandom, $urandom};
            pool_vlan[i] = 12'($urandom);
        end
        clock_now = '0;
        purged_at = '0;
        age_limit = 16'd300;
        purge_gap = 16'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_aging();
        test_full_table();
        test_random(240, 16'd5, 16'd3);
        test_random(240, 16'd1, 16'd1);
        test_random(240, 16'd300, 16'd1);
        test_random(240, 16'hffff, 16'd0);

        req_ch.valid <= 1'b0;
        req_done = 1'b1;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: directed cases, aging,", req_sent,
                 rsp_seen);
        $display("a full table with drops, and random traffic over four register settings.");
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("PASS mac_learning_table_with_aging");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL mac_learning_table_with_aging");
        end
        $finish;
    end
endmodule
`default_nettype wire
